/* hdl/tshb_pkg.sv */
// Shared types and constants for the timed sample history buffer.
package tshb_pkg;

    localparam int COUNT_BITS    = 11;
    localparam int STAMP_BITS    = 64;
    localparam int DATA_BITS     = 64;
    localparam int INDEX_BITS    = 10;
    localparam int MIN_INT_BITS  = 30;
    localparam int MAX_AGE_BITS  = 40;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 40;

    localparam logic [STAMP_BITS-1:0] ONE_SECOND_NS = 64'd1_000_000_000;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_AGE      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POINTS   = 2'd2;

    localparam logic [MIN_INT_BITS-1:0] MIN_INTERVAL_RESET = 30'd100_000_000;
    localparam logic [MAX_AGE_BITS-1:0] MAX_AGE_RESET      = 40'd30_000_000_000;
    localparam logic [COUNT_BITS-1:0]   MAX_POINTS_RESET   = 11'd1024;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_EXPIRE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                  command;
        logic [STAMP_BITS-1:0] stamp_ns;
        logic [DATA_BITS-1:0]  pose_payload;
        logic [INDEX_BITS-1:0] read_index;
    } item_t;

    typedef struct packed {
        logic [MIN_INT_BITS-1:0] min_interval;
        logic [MAX_AGE_BITS-1:0] max_age;
        logic [COUNT_BITS-1:0]   capacity;
    } cfg_t;

    typedef struct packed {
        logic                  ok;
        logic                  cleared;
        logic [COUNT_BITS-1:0] count;
        logic [STAMP_BITS-1:0] path_stamp_ns;
        logic                  read_valid;
        logic [STAMP_BITS-1:0] read_stamp_ns;
        logic [DATA_BITS-1:0]  read_payload;
    } result_t;

endpackage

/* hdl/tshb_store.sv */
// Sample memory holding stamps and payloads, one write and one registered read port.
module tshb_store #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [63:0]               wr_stamp,
    input  logic [PAYLOAD_BITS-1:0]   wr_payload,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [63:0]               rd_stamp,
    output logic [PAYLOAD_BITS-1:0]   rd_payload
);
    import tshb_pkg::*;

    logic [STAMP_BITS-1:0]   stamp_mem [DEPTH];
    logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr]   <= wr_stamp;
            payload_mem[wr_addr] <= wr_payload;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_stamp   <= stamp_mem[rd_addr];
            rd_payload <= payload_mem[rd_addr];
        end
    end

endmodule

/* hdl/tshb_cfg.sv */
// Configuration registers with capacity clamping.
module tshb_cfg #(
    parameter int DEPTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tshb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tshb_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output tshb_pkg::cfg_t                  cfg
);
    import tshb_pkg::*;

    localparam logic [COUNT_BITS-1:0] DEPTH_CAP = (DEPTH > 2047) ? 11'd2047 : 11'(DEPTH);

    logic [MIN_INT_BITS-1:0] min_interval_reg;
    logic [MAX_AGE_BITS-1:0] max_age_reg;
    logic [COUNT_BITS-1:0]   max_points_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= MIN_INTERVAL_RESET;
            max_age_reg      <= MAX_AGE_RESET;
            max_points_reg   <= MAX_POINTS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: min_interval_reg <= cfg_data[MIN_INT_BITS-1:0];
                REG_MAX_AGE:      max_age_reg      <= cfg_data[MAX_AGE_BITS-1:0];
                REG_MAX_POINTS:   max_points_reg   <= cfg_data[COUNT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.min_interval = min_interval_reg;
        cfg.max_age      = max_age_reg;
        if (max_points_reg == '0)
            cfg.capacity = 11'd1;
        else if ({21'd0, max_points_reg} > 32'(DEPTH))
            cfg.capacity = DEPTH_CAP;
        else
            cfg.capacity = max_points_reg;
    end

endmodule

/* hdl/tshb_ctrl.sv */
// Command sequencer: checks, ageing walk over the memory, commit and result register.
module tshb_ctrl #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tshb_pkg::item_t         item,
    input  tshb_pkg::cfg_t          cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tshb_pkg::result_t       result,
    output logic                    mem_wr_en,
    output logic [AW-1:0]           mem_wr_addr,
    output logic [63:0]             mem_wr_stamp,
    output logic [PAYLOAD_BITS-1:0] mem_wr_payload,
    output logic                    mem_rd_en,
    output logic [AW-1:0]           mem_rd_addr,
    input  logic [63:0]             mem_rd_stamp,
    input  logic [PAYLOAD_BITS-1:0] mem_rd_payload
);
    import tshb_pkg::*;

    localparam int SW = ((AW > COUNT_BITS) ? AW : COUNT_BITS) + 1;
    localparam logic [SW-1:0] DEPTH_W = SW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_TRIM,
        ST_COMMIT,
        ST_RDATA,
        ST_EMIT
    } state_t;

    function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                               input logic [COUNT_BITS-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offset);
        if (sum >= DEPTH_W)
            sum = sum - DEPTH_W;
        return sum[AW-1:0];
    endfunction

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [STAMP_BITS-1:0]   key_reg, key_next;
    logic [DATA_BITS-1:0]    pay_reg, pay_next;
    logic [INDEX_BITS-1:0]   idx_reg, idx_next;
    logic [AW-1:0]           oldest_reg, oldest_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [STAMP_BITS-1:0]   hist_reg, hist_next;
    logic [STAMP_BITS-1:0]   last_reg, last_next;
    logic                    ok_reg, ok_next;
    logic                    cl_reg, cl_next;
    logic                    dropped_reg, dropped_next;
    logic                    rv_reg, rv_next;
    logic [STAMP_BITS-1:0]   rstamp_reg, rstamp_next;
    logic [DATA_BITS-1:0]    rpay_reg, rpay_next;
    logic                    out_valid_reg, out_valid_next;
    result_t                 result_reg, result_next;

    logic                    out_free;
    logic [STAMP_BITS-1:0]   fwd_gap;
    logic [STAMP_BITS-1:0]   back_gap;
    logic [STAMP_BITS-1:0]   jump_limit;
    logic                    big_jump;
    logic                    aged;
    logic [AW-1:0]           oldest_inc;
    logic [COUNT_BITS-1:0]   count_dec;

    assign out_free   = !out_valid_reg || out_ready;
    assign fwd_gap    = key_reg - last_reg;
    assign back_gap   = last_reg - key_reg;
    assign jump_limit = ({24'd0, cfg.max_age} > ONE_SECOND_NS) ? {24'd0, cfg.max_age}
                                                               : ONE_SECOND_NS;
    assign big_jump   = (key_reg < last_reg) && (back_gap > jump_limit);
    assign aged       = (cfg.max_age != '0) && (key_reg > mem_rd_stamp)
                        && ((key_reg - mem_rd_stamp) > {24'd0, cfg.max_age});
    assign oldest_inc = slot_add(oldest_reg, 11'd1);
    assign count_dec  = count_reg - 11'd1;

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign mem_wr_stamp   = key_reg;
    assign mem_wr_payload = pay_reg[PAYLOAD_BITS-1:0];
    assign mem_wr_addr    = slot_add(oldest_reg, count_reg);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        pay_next       = pay_reg;
        idx_next       = idx_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        hist_next      = hist_reg;
        last_next      = last_reg;
        ok_next        = ok_reg;
        cl_next        = cl_reg;
        dropped_next   = dropped_reg;
        rv_next        = rv_reg;
        rstamp_next    = rstamp_reg;
        rpay_next      = rpay_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = oldest_reg;
        in_ready       = (state_reg == ST_IDLE) || ((state_reg == ST_EMIT) && out_free);

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_EVAL:
            begin
                unique case (cmd_reg)
                    CMD_APPEND:
                    begin
                        if (key_reg == '0)
                            state_next = ST_EMIT;
                        else if ((count_reg != '0) && (key_reg < last_reg))
                        begin
                            if (big_jump)
                            begin
                                oldest_next = '0;
                                count_next  = '0;
                                hist_next   = '0;
                                cl_next     = 1'b1;
                                state_next  = ST_TRIM;
                            end
                            else
                                state_next = ST_EMIT;
                        end
                        else if ((count_reg != '0) && ((key_reg == last_reg)
                                 || (fwd_gap < {34'd0, cfg.min_interval})))
                            state_next = ST_EMIT;
                        else if ((count_reg >= 11'd2) && (cfg.max_age != '0))
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = ST_WALK;
                        end
                        else
                            state_next = ST_TRIM;
                    end
                    CMD_EXPIRE:
                    begin
                        if ((key_reg == '0) || (count_reg == '0))
                            state_next = ST_EMIT;
                        else if (big_jump)
                        begin
                            oldest_next = '0;
                            count_next  = '0;
                            hist_next   = key_reg;
                            ok_next     = 1'b1;
                            cl_next     = 1'b1;
                            state_next  = ST_EMIT;
                        end
                        else if (cfg.max_age != '0)
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = ST_WALK;
                        end
                        else
                            state_next = ST_EMIT;
                    end
                    CMD_READ:
                    begin
                        if ({1'b0, idx_reg} < count_reg)
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = slot_add(oldest_reg, {1'b0, idx_reg});
                            state_next  = ST_RDATA;
                        end
                        else
                            state_next = ST_EMIT;
                    end
                    CMD_NOP:
                    begin
                        state_next = ST_EMIT;
                    end
                endcase
            end
            ST_WALK:
            begin
                mem_rd_addr = oldest_inc;
                if (cmd_reg == CMD_APPEND)
                begin
                    if (aged)
                    begin
                        oldest_next = oldest_inc;
                        count_next  = count_dec;
                        if (count_reg >= 11'd3)
                            mem_rd_en = 1'b1;
                        else
                            state_next = ST_TRIM;
                    end
                    else
                        state_next = ST_TRIM;
                end
                else
                begin
                    if (aged)
                    begin
                        oldest_next  = oldest_inc;
                        count_next   = count_dec;
                        dropped_next = 1'b1;
                    end
                    if (aged && (count_reg != 11'd1))
                        mem_rd_en = 1'b1;
                    else
                    begin
                        if (aged || dropped_reg)
                        begin
                            ok_next   = 1'b1;
                            hist_next = (count_next == '0) ? key_reg : last_reg;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_TRIM:
            begin
                if (count_reg >= cfg.capacity)
                begin
                    oldest_next = slot_add(oldest_reg, count_reg - cfg.capacity + 11'd1);
                    count_next  = cfg.capacity - 11'd1;
                end
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                mem_wr_en  = 1'b1;
                count_next = count_reg + 11'd1;
                hist_next  = key_reg;
                last_next  = key_reg;
                ok_next    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_RDATA:
            begin
                rv_next     = 1'b1;
                rstamp_next = mem_rd_stamp;
                rpay_next   = 64'(mem_rd_payload);
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    result_next.ok            = ok_reg;
                    result_next.cleared       = cl_reg;
                    result_next.count         = count_reg;
                    result_next.path_stamp_ns = hist_reg;
                    result_next.read_valid    = rv_reg;
                    result_next.read_stamp_ns = rstamp_reg;
                    result_next.read_payload  = rpay_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_valid && in_ready)
        begin
            cmd_next     = item.command;
            key_next     = item.stamp_ns;
            pay_next     = item.pose_payload;
            idx_next     = item.read_index;
            ok_next      = 1'b0;
            cl_next      = 1'b0;
            dropped_next = 1'b0;
            rv_next      = 1'b0;
            rstamp_next  = '0;
            rpay_next    = '0;
            state_next   = ST_EVAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmd_reg       <= CMD_NOP;
            key_reg       <= '0;
            pay_reg       <= '0;
            idx_reg       <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            hist_reg      <= '0;
            last_reg      <= '0;
            ok_reg        <= 1'b0;
            cl_reg        <= 1'b0;
            dropped_reg   <= 1'b0;
            rv_reg        <= 1'b0;
            rstamp_reg    <= '0;
            rpay_reg      <= '0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            key_reg       <= key_next;
            pay_reg       <= pay_next;
            idx_reg       <= idx_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            hist_reg      <= hist_next;
            last_reg      <= last_next;
            ok_reg        <= ok_next;
            cl_reg        <= cl_next;
            dropped_reg   <= dropped_next;
            rv_reg        <= rv_next;
            rstamp_reg    <= rstamp_next;
            rpay_reg      <= rpay_next;
            out_valid_reg <= out_valid_next;
            result_reg    <= result_next;
        end
    end

endmodule

/* hdl/timed_sample_history_buffer_core.sv */
// Top level of the timed sample history buffer.
//
// Each request on the s_ channel carries a command in s_tuser: append a timestamped
// sample, expire aged samples against the current time, read one entry counted from
// the oldest, or do nothing. Every request yields exactly one result on the m_ channel
// with the status flags, the entry count, the history stamp and any read data.
// Registers must be written through the cfg_ channel only while no request is in flight;
// the block itself does not enforce this. An append is evaluated, walks the oldest end
// if needed, trims and commits; an expire is evaluated and walks if needed; a read is
// evaluated and reads the memory; a rejected or empty request goes straight to its result.
// The ageing walk is bounded by the single read port of the sample memory, which
// delivers one stored stamp per cycle. Requests are handled one at a time; the next
// request is taken in the cycle its predecessor's result is registered.
// A registered result may wait on m_tready while the next request is already being
// worked on; that request's result then waits until the output register is free.
// Reset empties the buffer and restores the register defaults; the memory itself is
// not cleared, since entries are only read below the entry count.
module timed_sample_history_buffer_core #(
    parameter int DEPTH = 1024,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [143:0]                        s_tdata,   // stamp_ns, pose_payload, read_index
    input  logic [1:0]                          s_tuser,   // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // ok, cleared, count, path_stamp_ns, read_valid, read_stamp_ns, read_payload
    output logic [207:0]                        m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tshb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [tshb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tshb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    item_t                   item;
    cfg_t                    cfg;
    result_t                 result;
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic [63:0]             mem_wr_stamp;
    logic [PAYLOAD_BITS-1:0] mem_wr_payload;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [63:0]             mem_rd_stamp;
    logic [PAYLOAD_BITS-1:0] mem_rd_payload;

    assign item.command      = cmd_t'(s_tuser);
    assign item.stamp_ns     = s_tdata[63:0];
    assign item.pose_payload = s_tdata[127:64];
    assign item.read_index   = s_tdata[137:128];

    assign m_tdata[0]       = result.ok;
    assign m_tdata[1]       = result.cleared;
    assign m_tdata[12:2]    = result.count;
    assign m_tdata[76:13]   = result.path_stamp_ns;
    assign m_tdata[77]      = result.read_valid;
    assign m_tdata[141:78]  = result.read_stamp_ns;
    assign m_tdata[205:142] = result.read_payload;
    assign m_tdata[207:206] = 2'b00;

    tshb_cfg #(
        .DEPTH(DEPTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tshb_store #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .clk        (clk),
        .wr_en      (mem_wr_en),
        .wr_addr    (mem_wr_addr),
        .wr_stamp   (mem_wr_stamp),
        .wr_payload (mem_wr_payload),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_stamp   (mem_rd_stamp),
        .rd_payload (mem_rd_payload)
    );

    tshb_ctrl #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .item           (item),
        .cfg            (cfg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .result         (result),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_stamp   (mem_wr_stamp),
        .mem_wr_payload (mem_wr_payload),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_stamp   (mem_rd_stamp),
        .mem_rd_payload (mem_rd_payload)
    );

`ifndef SYNTHESIS
    a_count_in_depth: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({21'd0, m_tdata[12:2]} <= 32'(DEPTH)))
        else $error("Result count exceeds the buffer depth.");

    a_read_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[77]) |-> (!m_tdata[0] && !m_tdata[1]))
        else $error("A read result carries append or expire status.");

    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[77]) |-> ((m_tdata[141:78] == '0) && (m_tdata[205:142] == '0)))
        else $error("Read data is not zero on a result without a valid read.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("A request was taken while the previous one was still in progress.");
`endif

endmodule

/* tb/sv/timed_sample_history_buffer_core_tb.sv */
// Self-checking testbench for the timed sample history buffer core.
module timed_sample_history_buffer_core_tb;
    import tshb_pkg::*;

    localparam int RING_DEPTH = 1024;
    localparam int STALL_LIMIT = 10000;
    localparam int SETTLE_CYCLES = 16;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [143:0]             s_tdata = '0;
    logic [1:0]               s_tuser = CMD_NOP;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [207:0]             m_tdata;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    logic [63:0] ring_stamp [RING_DEPTH];
    logic [63:0] ring_payload [RING_DEPTH];
    int unsigned ring_head = 0;
    int unsigned held = 0;
    logic [63:0] track_stamp = '0;
    logic [63:0] spacing_reg = MIN_INTERVAL_RESET;
    logic [63:0] age_reg = MAX_AGE_RESET;
    int unsigned points_reg = MAX_POINTS_RESET;

    item_t       pending_requests[$];
    result_t     awaited_results[$];
    item_t       cur_req = '0;
    bit          req_live;
    int unsigned req_gap = 0;
    int unsigned rsp_wait = 0;
    bit          rsp_ready;
    bit          calm_phase = 1'b0;
    result_t     seen_res;
    result_t     want_res;
    int unsigned requests_made = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;
    logic [63:0] gen_time = '0;

    timed_sample_history_buffer_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned slot(int unsigned pos);
        return (ring_head + pos) % RING_DEPTH;
    endfunction

    function automatic bit is_stale(logic [63:0] now, logic [63:0] st);
        return age_reg != 0 && now > st && (now - st) > age_reg;
    endfunction

    function automatic result_t history_step(item_t req);
        result_t     res;
        logic [63:0] newest;
        logic [63:0] back_limit;
        int unsigned drop;
        int unsigned cap;
        bit          refuse;
        res = '0;
        back_limit = (age_reg > ONE_SECOND_NS) ? age_reg : ONE_SECOND_NS;
        newest = (held != 0) ? ring_stamp[slot(held - 1)] : '0;
        drop = 0;
        refuse = 1'b0;
        case (req.command)
            CMD_APPEND:
            begin
                if (req.stamp_ns == 0)
                    refuse = 1'b1;
                else if (held != 0)
                begin
                    if (req.stamp_ns < newest)
                    begin
                        if (newest - req.stamp_ns > back_limit)
                        begin
                            ring_head = 0;
                            held = 0;
                            track_stamp = '0;
                            res.cleared = 1'b1;
                        end
                        else
                            refuse = 1'b1;
                    end
                    else if (req.stamp_ns == newest || req.stamp_ns - newest < spacing_reg)
                        refuse = 1'b1;
                end
                if (!refuse)
                begin
                    while (held - drop >= 2 && is_stale(req.stamp_ns, ring_stamp[slot(drop)]))
                        drop++;
                    cap = (points_reg == 0) ? 1 :
                          (points_reg > RING_DEPTH) ? RING_DEPTH : points_reg;
                    if (held >= cap && drop < held - cap + 1)
                        drop = held - cap + 1;
                    ring_head = slot(drop);
                    held -= drop;
                    ring_stamp[slot(held)] = req.stamp_ns;
                    ring_payload[slot(held)] = req.pose_payload;
                    held++;
                    track_stamp = req.stamp_ns;
                    res.ok = 1'b1;
                end
            end
            CMD_EXPIRE:
            begin
                if (req.stamp_ns != 0 && held != 0)
                begin
                    if (req.stamp_ns < newest && newest - req.stamp_ns > back_limit)
                    begin
                        ring_head = 0;
                        held = 0;
                        track_stamp = req.stamp_ns;
                        res.ok = 1'b1;
                        res.cleared = 1'b1;
                    end
                    else
                    begin
                        while (drop < held && is_stale(req.stamp_ns, ring_stamp[slot(drop)]))
                            drop++;
                        if (drop != 0)
                        begin
                            ring_head = slot(drop);
                            held -= drop;
                            track_stamp = (held == 0) ? req.stamp_ns : ring_stamp[slot(held - 1)];
                            res.ok = 1'b1;
                        end
                    end
                end
            end
            CMD_READ:
            begin
                if (req.read_index < held)
                begin
                    res.read_valid = 1'b1;
                    res.read_stamp_ns = ring_stamp[slot(req.read_index)];
                    res.read_payload = ring_payload[slot(req.read_index)];
                end
            end
            default:
            begin
            end
        endcase
        res.count = COUNT_BITS'(held);
        res.path_stamp_ns = track_stamp;
        return res;
    endfunction

    function automatic logic [63:0] rand_below(logic [63:0] bound);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (bound == 0) ? 64'd0 : r % bound;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("result %0d: %s is %h, expected %h", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic push_req(cmd_t cmd, logic [63:0] stamp, logic [63:0] payload,
                            logic [INDEX_BITS-1:0] index);
        item_t req;
        req.command = cmd;
        req.stamp_ns = stamp;
        req.pose_payload = payload;
        req.read_index = index;
        pending_requests = {pending_requests, req};
        requests_made++;
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MIN_INTERVAL: spacing_reg = value[MIN_INT_BITS-1:0];
            REG_MAX_AGE:      age_reg = value[MAX_AGE_BITS-1:0];
            REG_MAX_POINTS:   points_reg = value[COUNT_BITS-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (results_seen != requests_made);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly appends, most of them well spaced along a running clock, mixed with expiry
    // ticks, reads, no-ops and the various kinds of refused or clearing stamps.
    task automatic queue_random_requests(int n, logic [63:0] spacing, logic [63:0] age_limit);
        logic [63:0] back;
        logic [63:0] stamp;
        logic [63:0] payload;
        logic [INDEX_BITS-1:0] index;
        int pick;
        int sub;
        back = (age_limit > ONE_SECOND_NS) ? age_limit : ONE_SECOND_NS;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            sub = $urandom_range(0, 99);
            stamp = {$urandom, $urandom};
            payload = {$urandom, $urandom};
            index = ($urandom_range(0, 9) < 7) ? INDEX_BITS'($urandom_range(0, 40)) :
                                                  INDEX_BITS'($urandom);
            if (pick < 55)
            begin
                if (sub < 60)
                begin
                    stamp = gen_time + spacing + rand_below(2 * spacing + 3);
                    gen_time = stamp;
                end
                else if (sub < 68)
                    stamp = gen_time + rand_below(spacing);
                else if (sub < 74)
                    stamp = gen_time - 1 - rand_below(back);
                else if (sub < 80)
                begin
                    if (gen_time > back + 64'd2000)
                        stamp = gen_time - back - 1 - rand_below(1000);
                    else
                        stamp = gen_time + spacing;
                    gen_time = stamp;
                end
                else if (sub < 84)
                    stamp = '0;
                else if (sub < 88)
                begin
                    if (stamp > gen_time)
                        gen_time = stamp;
                end
                else
                begin
                    stamp = gen_time + age_limit + rand_below(age_limit + 2) + spacing;
                    gen_time = stamp;
                end
                push_req(CMD_APPEND, stamp, payload, index);
            end
            else if (pick < 75)
            begin
                if (sub < 50)
                    stamp = gen_time + rand_below(2 * age_limit + 3);
                else if (sub < 65)
                    stamp = gen_time - rand_below(back);
                else if (sub < 80)
                    stamp = (gen_time > back + 64'd2000) ? gen_time - back - 1 - rand_below(1000)
                                                         : gen_time;
                else if (sub < 88)
                    stamp = '0;
                push_req(CMD_EXPIRE, stamp, payload, index);
            end
            else if (pick < 95)
                push_req(CMD_READ, stamp, payload, index);
            else
                push_req(CMD_NOP, stamp, payload, index);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            req_gap = 0;
        end
        else
        begin
            req_live = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                awaited_results = {awaited_results, history_step(cur_req)};
                req_live = 1'b0;
            end
            if (!req_live)
            begin
                if (req_gap != 0)
                    req_gap--;
                else if (pending_requests.size() != 0)
                begin
                    cur_req = pending_requests.pop_front();
                    req_gap = calm_phase ? 0 : $urandom_range(0, 9);
                    req_live = 1'b1;
                end
            end
            s_tvalid <= req_live;
            s_tdata <= {6'b0, cur_req.read_index, cur_req.pose_payload, cur_req.stamp_ns};
            s_tuser <= cur_req.command;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rsp_wait = 0;
        end
        else
        begin
            rsp_ready = m_tready;
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                seen_res.ok = m_tdata[0];
                seen_res.cleared = m_tdata[1];
                seen_res.count = m_tdata[12:2];
                seen_res.path_stamp_ns = m_tdata[76:13];
                seen_res.read_valid = m_tdata[77];
                seen_res.read_stamp_ns = m_tdata[141:78];
                seen_res.read_payload = m_tdata[205:142];
                if (awaited_results.size() == 0)
                    report_mismatch("result with none expected, path stamp",
                                    seen_res.path_stamp_ns, '0);
                else
                begin
                    want_res = awaited_results.pop_front();
                    if (seen_res.ok !== want_res.ok)
                        report_mismatch("ok", seen_res.ok, want_res.ok);
                    if (seen_res.cleared !== want_res.cleared)
                        report_mismatch("cleared", seen_res.cleared, want_res.cleared);
                    if (seen_res.count !== want_res.count)
                        report_mismatch("count", seen_res.count, want_res.count);
                    if (seen_res.path_stamp_ns !== want_res.path_stamp_ns)
                        report_mismatch("path_stamp_ns", seen_res.path_stamp_ns,
                                        want_res.path_stamp_ns);
                    if (seen_res.read_valid !== want_res.read_valid)
                        report_mismatch("read_valid", seen_res.read_valid, want_res.read_valid);
                    if (seen_res.read_stamp_ns !== want_res.read_stamp_ns)
                        report_mismatch("read_stamp_ns", seen_res.read_stamp_ns,
                                        want_res.read_stamp_ns);
                    if (seen_res.read_payload !== want_res.read_payload)
                        report_mismatch("read_payload", seen_res.read_payload,
                                        want_res.read_payload);
                end
                rsp_wait = calm_phase ? 0 : $urandom_range(0, 9);
                rsp_ready = (rsp_wait == 0);
            end
            else if (!m_tready)
            begin
                if (rsp_wait != 0)
                    rsp_wait--;
                rsp_ready = (rsp_wait == 0);
            end
            m_tready <= rsp_ready;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timed_sample_history_buffer_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int          stage;
        logic [63:0] spacing;
        logic [63:0] age_limit;
        logic [63:0] points;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        push_req(CMD_READ, 64'd0, 64'd0, 10'd0);
        push_req(CMD_READ, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF);
        push_req(CMD_EXPIRE, 64'd1_000_000_000, 64'd0, 10'd0);
        push_req(CMD_APPEND, 64'd0, 64'h1234_5678_9ABC_DEF0, 10'd0);
        push_req(CMD_APPEND, 64'd1_000_000_000, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        push_req(CMD_APPEND, 64'd1_000_000_000, 64'h1, 10'd0);
        push_req(CMD_APPEND, 64'd1_050_000_000, 64'h2, 10'd0);
        push_req(CMD_APPEND, 64'd1_100_000_000, 64'h0, 10'd0);
        push_req(CMD_APPEND, 64'd1_050_000_000, 64'h3, 10'd0);
        push_req(CMD_READ, 64'd0, 64'd0, 10'd0);
        push_req(CMD_READ, 64'd0, 64'd0, 10'd1);
        push_req(CMD_READ, 64'd0, 64'd0, 10'd2);
        push_req(CMD_EXPIRE, 64'd0, 64'd0, 10'd0);
        push_req(CMD_EXPIRE, 64'd31_000_000_000, 64'd0, 10'd0);
        push_req(CMD_EXPIRE, 64'd31_000_000_001, 64'd0, 10'd0);
        // A lone aged entry survives an append; with two aged entries, only the older one goes.
        push_req(CMD_APPEND, 64'd100_000_000_000, 64'hA5A5_A5A5_5A5A_5A5A, 10'd0);
        push_req(CMD_APPEND, 64'd200_000_000_000, 64'h5A5A_5A5A_A5A5_A5A5, 10'd0);
        push_req(CMD_EXPIRE, 64'd169_999_999_999, 64'd0, 10'd0);
        push_req(CMD_APPEND, 64'd300_000_000_000, 64'hDEAD_BEEF_0000_0001, 10'd0);
        push_req(CMD_APPEND, 64'd269_999_999_999, 64'hDEAD_BEEF_0000_0002, 10'd0);
        push_req(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 10'd0);
        push_req(CMD_READ, 64'd0, 64'd0, 10'd1);
        push_req(CMD_EXPIRE, 64'd5, 64'd0, 10'd0);
        push_req(CMD_NOP, {$urandom, $urandom}, {$urandom, $urandom}, 10'h155);

        for (stage = 0; stage < 8; stage++)
        begin
            wait_drained();
            case (stage)
                0:
                begin
                    spacing = 64'd1; age_limit = 64'd0; points = 64'd1024;
                    gen_time = 64'd1000;
                end
                1:
                begin
                    spacing = 64'd1000; age_limit = 64'd5000; points = 64'd8;
                    gen_time = 64'd5_000_000_000;
                end
                2:
                begin
                    spacing = 64'd0; age_limit = 64'd1_000_000_000_000; points = 64'd1;
                    gen_time = 64'd2_000_000_000_000;
                end
                3:
                begin
                    spacing = 64'h3FFF_FFFF; age_limit = 64'hFF_FFFF_FFFF; points = 64'd2047;
                    gen_time = 64'hFFFF_FF00_0000_0000;
                end
                4:
                begin
                    spacing = 64'd1_000_000_000; age_limit = 64'd1_000_000_001; points = 64'd0;
                    gen_time = 64'd7_000_000_000_000;
                end
                5:
                begin
                    spacing = 64'd50; age_limit = 64'd400; points = 64'd16;
                    gen_time = 64'd12345;
                end
                6:
                begin
                    spacing = 64'd3; age_limit = 64'd2_000_000_000; points = 64'd2;
                    gen_time = 64'd1_000_000_000_000_000;
                end
                default:
                begin
                    spacing = MIN_INTERVAL_RESET; age_limit = MAX_AGE_RESET;
                    points = MAX_POINTS_RESET; gen_time = 64'd9_000_000_000_000_000;
                end
            endcase
            write_register(REG_MIN_INTERVAL, CFG_DATA_BITS'(spacing));
            write_register(REG_MAX_AGE, CFG_DATA_BITS'(age_limit));
            write_register(REG_MAX_POINTS, CFG_DATA_BITS'(points));
            calm_phase = (stage == 2 || stage == 5);
            queue_random_requests(105, spacing, age_limit);
        end

        wait_drained();
        if (mismatches == 0)
            $display("timed_sample_history_buffer_core verification clean");
        else
            $display("timed_sample_history_buffer_core verification failed");
        $finish;
    end

endmodule
